FILE: sv/gws_pkg.sv
// Shared types and constants for the G-code word splitter.
`default_nettype none

package gws_pkg;

	// Character codes that steer the scanner.
	localparam logic [7:0] CHAR_SEMI   = 8'h3B;
	localparam logic [7:0] CHAR_LPAREN = 8'h28;
	localparam logic [7:0] CHAR_RPAREN = 8'h29;
	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_LBRACK = 8'h5B;
	localparam logic [7:0] CHAR_RBRACK = 8'h5D;

	// Default number of entries in the queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Scanner modes.
	typedef enum logic [2:0] {
		SCAN_NORMAL   = 3'd0,
		SCAN_COMMENT  = 3'd1,
		SCAN_DOLLAR   = 3'd2,
		SCAN_DCOMMENT = 3'd3,
		SCAN_SKIP     = 3'd4
	} gws_scan_t;

	// One input item.
	typedef struct packed {
		logic [7:0] in_char;
		logic       line_end;
	} gws_in_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       word_start;
		logic       line_done;
		logic       line_had_words;
	} gws_out_t;

	// A classified character as it travels through the queue.
	typedef struct packed {
		logic [7:0] ch;
		logic       line_end;
		logic       is_blank;
		logic       is_semi;
		logic       is_lparen;
		logic       is_rparen;
		logic       is_bracket;
		logic       is_letter;
		logic       is_dollar;
	} gws_item_t;

endpackage

`default_nettype wire

FILE: sv/gws_front.sv
// Front end: accepts characters and classifies them for the scanner.
`default_nettype none

module gws_front
	import gws_pkg::*;
(
	input  wire gws_in_t   in_data,
	output gws_item_t      item
);

	logic [7:0] c;

	assign c = in_data.in_char;

	// Decode the character into the flags the scanner needs.
	always_comb begin
		item.ch         = c;
		item.line_end   = in_data.line_end;
		item.is_blank   = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
		item.is_semi    = (c == CHAR_SEMI);
		item.is_lparen  = (c == CHAR_LPAREN);
		item.is_rparen  = (c == CHAR_RPAREN);
		item.is_bracket = (c == CHAR_LBRACK) || (c == CHAR_RBRACK);
		item.is_dollar  = (c == CHAR_DOLLAR);
		item.is_letter  = (c == "G") || (c == "M") || (c == "T") || (c == "S") ||
			(c == "F") || (c == "X") || (c == "Y") || (c == "Z") ||
			(c == "I") || (c == "J") || (c == CHAR_DOLLAR);
	end

endmodule

`default_nettype wire

FILE: sv/gws_fifo.sv
// Short queue of classified characters between front and back.
`default_nettype none

module gws_fifo
	import gws_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  wire gws_item_t  push_item,
	output logic            full,
	input  wire             pop,
	output logic            not_empty,
	output gws_item_t       head
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	gws_item_t            mem_q [DEPTH];
	logic [PtrW-1:0]      wr_ptr_q;
	logic [PtrW-1:0]      rd_ptr_q;
	logic [CntW-1:0]      count_q;

	assign full      = (count_q == CntW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	// The fill count never passes the depth.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CntW'(DEPTH))
		else $error("queue count above depth");

	// A push alone raises the count by one.
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + CntW'(1))
		else $error("queue count did not follow a push");

	// Nothing is popped from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: sv/gws_back.sv
// Back end: the scanner state machine and the result register.
`default_nettype none

module gws_back
	import gws_pkg::*;
(
	input  wire             clk,
	input  wire             arst_n,
	input  wire             item_valid,
	input  wire gws_item_t  item,
	output logic            pop,
	output logic            out_valid,
	input  wire             out_ready,
	output gws_out_t        out_data
);

	gws_scan_t mode_q;
	gws_scan_t mode_d;
	logic      word_open_q;
	logic      word_open_d;
	logic      keep;
	logic      start;
	logic      emit;
	logic      out_valid_q;
	gws_out_t  out_q;
	gws_out_t  res;

	// Take the next item whenever the result register is free or draining.
	assign pop = item_valid && (!out_valid_q || out_ready);

	// Next mode and word state.
	always_comb begin
		mode_d      = mode_q;
		word_open_d = word_open_q;
		case (mode_q)
			SCAN_SKIP: begin
				mode_d = SCAN_SKIP;
			end
			SCAN_COMMENT: begin
				if (item.is_rparen) mode_d = SCAN_NORMAL;
			end
			SCAN_DCOMMENT: begin
				if (item.is_rparen) mode_d = SCAN_DOLLAR;
			end
			SCAN_DOLLAR: begin
				if (item.is_blank) mode_d = SCAN_NORMAL;
				else if (item.is_semi) mode_d = SCAN_SKIP;
				else if (item.is_lparen) mode_d = SCAN_DCOMMENT;
				else word_open_d = 1'b1;
			end
			default: begin
				if (item.is_semi) mode_d = SCAN_SKIP;
				else if (item.is_lparen) mode_d = SCAN_COMMENT;
				else if (!(item.is_bracket || item.is_blank)) begin
					word_open_d = 1'b1;
					mode_d      = item.is_dollar ? SCAN_DOLLAR : SCAN_NORMAL;
				end
			end
		endcase
	end

	// Keep and word-start decisions for the current item.
	always_comb begin
		keep  = 1'b0;
		start = 1'b0;
		case (mode_q)
			SCAN_SKIP, SCAN_COMMENT, SCAN_DCOMMENT: begin
				keep = 1'b0;
			end
			SCAN_DOLLAR: begin
				keep  = !(item.is_blank || item.is_semi || item.is_lparen);
				start = !word_open_q;
			end
			default: begin
				keep  = !(item.is_semi || item.is_lparen || item.is_bracket || item.is_blank);
				start = !word_open_q || item.is_letter;
			end
		endcase
		emit                = keep || item.line_end;
		res.out_char        = keep ? item.ch : 8'd0;
		res.char_valid      = keep;
		res.word_start      = keep && start;
		res.line_done       = item.line_end;
		res.line_had_words  = item.line_end && (word_open_q || keep);
	end

	// Scanner state; the end of a line returns it to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= SCAN_NORMAL;
			word_open_q <= 1'b0;
		end else if (pop) begin
			if (item.line_end) begin
				mode_q      <= SCAN_NORMAL;
				word_open_q <= 1'b0;
			end else begin
				mode_q      <= mode_d;
				word_open_q <= word_open_d;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// After the last item of a line the scanner is back at reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && item.line_end |=> mode_q == SCAN_NORMAL && !word_open_q)
		else $error("scanner not reset after end of line");

	// A held result is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !(out_valid_q && !out_ready))
		else $error("result overwritten while stalled");

	// A word start only comes with a kept character.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.word_start |-> out_q.char_valid)
		else $error("word start without a kept character");

	// Line summary only appears on the end-of-line result.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.line_done |-> !out_q.line_had_words)
		else $error("line summary outside end of line");

endmodule

`default_nettype wire

FILE: sv/gcode_word_splitter_core.sv
// Top level of the G-code word splitter.
`default_nettype none

// The splitter takes one character of a G-code line per item and gives at
// most one result per item: a kept character marked when it starts a word,
// and on the line's last character an end mark with whether any character
// was kept. It sustains one item per clock cycle when the output side is
// ready. An item passes through the classifier, a queue of QUEUE_DEPTH
// entries and the scanner: the queue registers the item, and its result,
// if any, is offered from the result register that the scanner writes; the
// scanner's state update sets the rate. Input ready drops only when the
// queue is full.
module gcode_word_splitter_core
	import gws_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  wire gws_in_t    in_data,
	output logic            out_valid,
	input  wire             out_ready,
	output gws_out_t        out_data
);

	gws_item_t front_item;
	gws_item_t head_item;
	logic      q_full;
	logic      q_not_empty;
	logic      q_pop;
	logic      q_push;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	// Character classification.
	gws_front u_front (
		.in_data (in_data),
		.item    (front_item)
	);

	// Decoupling queue.
	gws_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_item)
	);

	// Scanner and result register.
	gws_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_not_empty),
		.item       (head_item),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

FILE: tb/gws_tb_pkg.sv
// Scoreboard class that predicts and checks the word splitter's results.
package gws_tb_pkg;

	import gws_pkg::*;

	// Blank characters besides the space: the control range from tab to CR.
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	class word_split_checker;

		gws_scan_t   mode;
		bit          word_open;
		gws_out_t    expected_q[$];
		int          mismatches;
		int          checked;

		function new();
			mode = SCAN_NORMAL;
			word_open = 1'b0;
			mismatches = 0;
			checked = 0;
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function bit is_word_letter(logic [7:0] c);
			return c inside {"G", "M", "T", "S", "F", "X", "Y", "Z", "I", "J",
				CHAR_DOLLAR};
		endfunction

		function int pending_count();
			return expected_q.size();
		endfunction

		// Advance the scanner by one accepted item and queue the result it causes.
		function void note_char(gws_in_t it);
			logic [7:0] c;
			bit         keep;
			bit         start;
			gws_out_t   r;
			c = it.in_char;
			keep = 1'b0;
			start = 1'b0;
			case (mode)
				SCAN_SKIP: begin
				end
				SCAN_COMMENT: begin
					if (c == CHAR_RPAREN) mode = SCAN_NORMAL;
				end
				SCAN_DCOMMENT: begin
					if (c == CHAR_RPAREN) mode = SCAN_DOLLAR;
				end
				SCAN_DOLLAR: begin
					// Inside a dollar word everything but blanks, comments and ';' is kept.
					if (is_blank(c)) begin
						mode = SCAN_NORMAL;
					end else if (c == CHAR_SEMI) begin
						mode = SCAN_SKIP;
					end else if (c == CHAR_LPAREN) begin
						mode = SCAN_DCOMMENT;
					end else begin
						keep = 1'b1;
						start = !word_open;
						word_open = 1'b1;
					end
				end
				default: begin
					if (c == CHAR_SEMI) begin
						mode = SCAN_SKIP;
					end else if (c == CHAR_LPAREN) begin
						mode = SCAN_COMMENT;
					end else if (c != CHAR_LBRACK && c != CHAR_RBRACK && !is_blank(c)) begin
						keep = 1'b1;
						start = !word_open || is_word_letter(c);
						word_open = 1'b1;
						if (c == CHAR_DOLLAR) mode = SCAN_DOLLAR;
						else mode = SCAN_NORMAL;
					end
				end
			endcase

			// Dropped characters give nothing unless they close the line.
			if (!keep && !it.line_end) return;
			r.out_char = keep ? c : 8'h00;
			r.char_valid = keep;
			r.word_start = start;
			r.line_done = it.line_end;
			r.line_had_words = it.line_end ? word_open : 1'b0;
			expected_q.insert(expected_q.size(), r);
			if (it.line_end) begin
				mode = SCAN_NORMAL;
				word_open = 1'b0;
			end
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		// Compare one accepted result with the oldest prediction.
		function void check_result(gws_out_t got);
			gws_out_t want;
			checked++;
			if (expected_q.size() == 0) begin
				$error("result with nothing predicted: out_char %0d line_done %0d",
					got.out_char, got.line_done);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("out_char", want.out_char, got.out_char);
			compare_field("char_valid", want.char_valid, got.char_valid);
			compare_field("word_start", want.word_start, got.word_start);
			compare_field("line_done", want.line_done, got.line_done);
			compare_field("line_had_words", want.line_had_words, got.line_had_words);
		endfunction

	endclass

endpackage

FILE: tb/tb_top.sv
// Top-level testbench for the G-code word splitter core.
module tb_top;

	import gws_pkg::*;
	import gws_tb_pkg::*;

	localparam int ITEM_TARGET = 1650;
	localparam int HOLD_CYCLES = 80;
	localparam int HOLD_AFTER = 250;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	gws_in_t    in_data;
	logic       out_valid;
	logic       out_ready;
	gws_out_t   out_data;

	word_split_checker sb = new();

	int         items_sent;
	int         tx_calm;
	logic [7:0] line_buf[$];

	gcode_word_splitter_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshakes hang.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// Idle cycles before the next item, with occasional stretches of none.
	function automatic int draw_wait(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 6);
	endfunction

	// Offer one character and hold it until the block takes it.
	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		gap = draw_wait(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{in_char: c, line_end: last};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_char(in_data);
		items_sent++;
	endtask

	// Send a whole line of text, marking its last character.
	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], i == s.len() - 1);
		end
	endtask

	function automatic logic [7:0] pick_blank();
		if ($urandom_range(0, 1) != 0) return CH_SPACE;
		return 8'($urandom_range(CH_TAB, CH_CR));
	endfunction

	// Append one byte to the line being built.
	function automatic void add_byte(logic [7:0] b);
		line_buf.insert(line_buf.size(), b);
	endfunction

	// Build a mostly well-formed G-code line with random words, comments,
	// dollar words, brackets, stray bytes and an occasional ';' tail.
	function automatic void build_line();
		string num_chars;
		string letters;
		string dollar_chars;
		int    pieces;
		int    kind;
		num_chars = "0123456789.-";
		letters = "GMTSFXYZIJgxab";
		dollar_chars = "AbG[]$1=(z)";
		line_buf.delete();
		pieces = $urandom_range(1, 6);
		for (int p = 0; p < pieces; p++) begin
			kind = $urandom_range(0, 11);
			if (kind <= 5) begin
				add_byte(letters[$urandom_range(0, letters.len() - 1)]);
				repeat ($urandom_range(0, 4))
					add_byte(num_chars[$urandom_range(0, num_chars.len() - 1)]);
			end else if (kind == 6) begin
				add_byte(CHAR_LPAREN);
				repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(32, 126)));
				if ($urandom_range(0, 9) != 0) add_byte(CHAR_RPAREN);
			end else if (kind == 7) begin
				add_byte(CHAR_DOLLAR);
				repeat ($urandom_range(0, 5))
					add_byte(dollar_chars[$urandom_range(0, dollar_chars.len() - 1)]);
			end else if (kind == 8) begin
				repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range(0, 255)));
			end else if (kind == 9) begin
				add_byte(($urandom_range(0, 1) != 0) ? CHAR_LBRACK : CHAR_RBRACK);
			end else begin
				add_byte(pick_blank());
			end
			if ($urandom_range(0, 9) < 6) add_byte(pick_blank());
		end
		if ($urandom_range(0, 7) == 0) begin
			add_byte(CHAR_SEMI);
			repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(32, 126)));
		end
	endfunction

	// Result side: random stalls plus one long hold-off to fill the block.
	initial begin : result_sink
		int wait_cycles;
		int rx_calm;
		bit held;
		rx_calm = 0;
		held = 1'b0;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			wait_cycles = draw_wait(rx_calm);
			if (!held && sb.checked >= HOLD_AFTER) begin
				held = 1'b1;
				wait_cycles = HOLD_CYCLES;
			end
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_result(out_data);
		end
	end

	// Reset, directed lines, random lines, then drain.
	initial begin
		items_sent = 0;
		tx_calm = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Byte extremes: a non-letter still opens the first word.
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		// A line that is only a blank ends with no words.
		send_char(CH_SPACE, 1'b1);
		// Letters, lower case, comment, brackets, dollar word with a comment,
		// blank closing the dollar word, and a skipped last character.
		send_text("G1x(c)[Y]$A[G(z)] ;q");
		// A ';' inside a dollar word, then an unclosed comment.
		send_text("$a;(");
		send_text("(o");

		while (items_sent < ITEM_TARGET) begin
			build_line();
			foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
		end
		in_valid <= 1'b0;

		while (sb.pending_count() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/gws_pkg.sv
sv/gws_front.sv
sv/gws_fifo.sv
sv/gws_back.sv
sv/gcode_word_splitter_core.sv
tb/gws_tb_pkg.sv
tb/tb_top.sv
